// ===== design/bspu_pkg.sv =====
package bspu_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RED_MASK     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN_MASK   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE_MASK    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH   = 3'd4;

    localparam logic [31:0] CHAN_RED   = 32'h00FF_0000;
    localparam logic [31:0] CHAN_GREEN = 32'h0000_FF00;
    localparam logic [31:0] CHAN_BLUE  = 32'h0000_00FF;

    localparam logic [5:0] TOP_RED   = 6'd24;
    localparam logic [5:0] TOP_GREEN = 6'd16;
    localparam logic [5:0] TOP_BLUE  = 6'd8;

    typedef enum logic [2:0] {
        FMT_1BPP  = 3'd0,
        FMT_4BPP  = 3'd1,
        FMT_8BPP  = 3'd2,
        FMT_16BPP = 3'd3,
        FMT_24BPP = 3'd4,
        FMT_32BPP = 3'd5
    } pix_fmt_t;

    typedef enum logic {
        KIND_PAL_WR = 1'b0,
        KIND_DATA   = 1'b1
    } item_kind_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } seq_state_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  idx;
        logic [31:0] word;
    } q_entry_t;

    typedef struct packed {
        pix_fmt_t    fmt;
        logic [31:0] red_mask;
        logic [31:0] green_mask;
        logic [31:0] blue_mask;
        logic [5:0]  red_len;
        logic [5:0]  green_len;
        logic [5:0]  blue_len;
        logic [12:0] line_width;
    } cfg_t;

endpackage

// ===== design/bmp_scanline_pixel_unpacker.sv =====
// Path: a word passes the queue and the sequencer's word register; each pixel then
// passes the lookup stage and the output register. Throughput: one pixel per cycle
// while words are queued and the output is free; a word yields 1 to 32 pixels.
// A 4-entry queue parts the input side from the sequencer.
// Reset: control state cleared, registers to defaults; palette undefined until written.
module bmp_scanline_pixel_unpacker
    import bspu_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int PALETTE_DEPTH  = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,  // data_word, palette_index
    input  logic                  s_axis_tuser,  // command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // pixel
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser   // line_end
);

    cfg_t     cfg;
    logic     q_full;
    logic     q_push;
    q_entry_t q_in;
    logic     q_pop;
    logic     q_valid;
    q_entry_t q_out;

    bspu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_in),
        .cfg           (cfg)
    );

    bspu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .dout      (q_out)
    );

    bspu_back #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
        .PALETTE_DEPTH  (PALETTE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_entry       (q_out),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== design/bspu_front.sv =====
module bspu_front
    import bspu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [31:0]           cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  q_full,
    output logic                  q_push,
    output q_entry_t              q_entry,
    output cfg_t                  cfg
);

    localparam cfg_t CFG_RESET = '{
        fmt:        FMT_24BPP,
        red_mask:   CHAN_RED,
        green_mask: CHAN_GREEN,
        blue_mask:  CHAN_BLUE,
        red_len:    TOP_RED,
        green_len:  TOP_GREEN,
        blue_len:   TOP_BLUE,
        line_width: 13'd1
    };

    function automatic logic [5:0] bit_len(logic [31:0] v);
        logic [5:0] len;
        len = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (v[i])
            begin
                len = 6'(i + 1);
            end
        end
        return len;
    endfunction

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [5:0] data_len;
    logic       accept;
    logic       fmt_ok;

    assign data_len = bit_len(cfg_data);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_PIXEL_FORMAT: cfg_next.fmt = pix_fmt_t'(cfg_data[2:0]);
                REG_RED_MASK:
                begin
                    cfg_next.red_mask = cfg_data;
                    cfg_next.red_len  = data_len;
                end
                REG_GREEN_MASK:
                begin
                    cfg_next.green_mask = cfg_data;
                    cfg_next.green_len  = data_len;
                end
                REG_BLUE_MASK:
                begin
                    cfg_next.blue_mask = cfg_data;
                    cfg_next.blue_len  = data_len;
                end
                REG_LINE_WIDTH:   cfg_next.line_width = cfg_data[12:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // drop data beats while the format code is undefined
    assign fmt_ok        = cfg_reg.fmt inside {[FMT_1BPP:FMT_32BPP]};
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign q_push        = accept && (item_kind_t'(s_axis_tuser) == KIND_PAL_WR || fmt_ok);

    assign q_entry.kind = item_kind_t'(s_axis_tuser);
    assign q_entry.idx  = s_axis_tdata[7:0];
    assign q_entry.word = s_axis_tdata[39:8];
    assign cfg          = cfg_reg;

endmodule

// ===== design/bspu_fifo.sv =====
module bspu_fifo
    import bspu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t din,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output q_entry_t dout
);

    q_entry_t        q_mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_AW:0]   cnt_reg;
    logic [Q_AW:0]   cnt_next;

    assign full      = cnt_reg == (Q_AW + 1)'(Q_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign dout      = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ===== design/bspu_back.sv =====
module bspu_back
    import bspu_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096,
    parameter int PALETTE_DEPTH  = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  q_entry_t    q_entry,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic        m_axis_tlast,
    output logic        m_axis_tuser
);

    localparam int CW   = $clog2(MAX_LINE_WIDTH);
    localparam int CMPW = (CW + 1 > 13) ? CW + 1 : 13;
    localparam int PW   = $clog2(PALETTE_DEPTH);
    localparam logic [CMPW-1:0] MAXW = CMPW'(MAX_LINE_WIDTH);

    function automatic logic [255:0][7:0] build_mod_table(int depth);
        logic [255:0][7:0] tbl;
        int                r;
        r = 0;
        for (int i = 0; i < 256; i++)
        begin
            tbl[i] = 8'(r);
            r      = (r + 1 == depth) ? 0 : r + 1;
        end
        return tbl;
    endfunction

    localparam logic [255:0][7:0] MOD_TBL = build_mod_table(PALETTE_DEPTH);

    function automatic logic [31:0] place_field(logic [31:0] raw, logic [31:0] mask,
                                                logic [5:0] len, logic [5:0] top);
        logic [31:0] f;
        f = raw & mask;
        if (len <= top)
        begin
            f = f << (top - len);
        end
        else
        begin
            f = f >> (len - top);
        end
        return f;
    endfunction

    seq_state_t      state_reg;
    seq_state_t      state_next;
    logic [31:0]     word_reg;
    logic [31:0]     word_next;
    logic [4:0]      j_reg;
    logic [4:0]      j_next;
    logic [47:0]     rgb_buf_reg;
    logic [47:0]     rgb_buf_next;
    logic [2:0]      rem_reg;
    logic [2:0]      rem_next;
    logic [15:0]     carry_reg;
    logic [15:0]     carry_next;
    logic [1:0]      carry_cnt_reg;
    logic [1:0]      carry_cnt_next;
    logic [CW-1:0]   pil_reg;
    logic [CW-1:0]   pil_next;
    logic [CMPW-1:0] eff_reg;
    logic [CMPW-1:0] eff_next;
    logic [CMPW-1:0] lw_ext;

    logic            s2_valid_reg;
    logic            s2_pal_reg;
    logic            s2_last_reg;
    logic            s2_end_reg;
    logic [31:0]     s2_pix_reg;
    logic [31:0]     pal_q_reg;
    logic            out_valid_reg;
    logic [31:0]     out_pix_reg;
    logic            out_last_reg;
    logic            out_end_reg;

    logic [31:0]     pal_mem [PALETTE_DEPTH];

    logic            advance;
    logic            running;
    logic            issue;
    logic            load;
    logic            pal_we;
    logic            finish;
    logic            line_end;
    logic            word_done;
    logic            step_last;
    logic            use_pal;
    logic            use_direct;
    logic [7:0]      idx;
    logic [31:0]     raw;
    logic [31:0]     conv_pix;
    logic [15:0]     carry_fin;
    logic [1:0]      carry_cnt_fin;
    logic [15:0]     carry_cur;
    logic [1:0]      carry_cnt_cur;
    logic [PW-1:0]   waddr;
    logic [PW-1:0]   raddr;

    assign advance  = !out_valid_reg || m_axis_tready;
    assign running  = state_reg == SEQ_RUN;
    assign line_end = (CMPW'(pil_reg) + CMPW'(1)) >= eff_reg;

    always_comb
    begin
        idx        = '0;
        raw        = word_reg;
        word_done  = 1'b1;
        use_pal    = 1'b0;
        use_direct = 1'b0;
        case (cfg.fmt)
            FMT_1BPP:
            begin
                idx       = {7'b0, word_reg[{j_reg[4:3], ~j_reg[2:0]}]};
                word_done = j_reg == 5'd31;
                use_pal   = 1'b1;
            end
            FMT_4BPP:
            begin
                idx       = {4'b0, word_reg[{j_reg[2:1], ~j_reg[0], 2'b00} +: 4]};
                word_done = j_reg == 5'd7;
                use_pal   = 1'b1;
            end
            FMT_8BPP:
            begin
                idx       = word_reg[{j_reg[1:0], 3'b000} +: 8];
                word_done = j_reg == 5'd3;
                use_pal   = 1'b1;
            end
            FMT_16BPP:
            begin
                raw       = {16'b0, word_reg[{j_reg[0], 4'b0000} +: 16]};
                word_done = j_reg == 5'd1;
            end
            FMT_24BPP:
            begin
                word_done  = rem_reg < 3'd6;
                use_direct = 1'b1;
            end
            default:
            begin
                raw       = word_reg;
                word_done = 1'b1;
            end
        endcase
    end

    assign step_last = word_done || line_end;
    assign conv_pix  = (place_field(raw, cfg.red_mask, cfg.red_len, TOP_RED) & CHAN_RED)
                     | (place_field(raw, cfg.green_mask, cfg.green_len, TOP_GREEN) & CHAN_GREEN)
                     | (place_field(raw, cfg.blue_mask, cfg.blue_len, TOP_BLUE) & CHAN_BLUE);

    // sequencer outputs
    always_comb
    begin
        issue  = 1'b0;
        finish = 1'b0;
        q_pop  = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                q_pop = q_valid;
            end
            SEQ_RUN:
            begin
                issue  = advance;
                finish = advance && step_last;
                q_pop  = q_valid && advance && step_last;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
        load   = q_pop && q_entry.kind == KIND_DATA;
        pal_we = q_pop && q_entry.kind == KIND_PAL_WR;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (load)
                begin
                    state_next = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                if (finish)
                begin
                    state_next = load ? SEQ_RUN : SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cfg.fmt == FMT_24BPP && !line_end)
        begin
            carry_fin     = rgb_buf_reg[39:24];
            carry_cnt_fin = 2'(rem_reg - 3'd3);
        end
        else
        begin
            carry_fin     = '0;
            carry_cnt_fin = '0;
        end
        carry_cur     = finish ? carry_fin : carry_reg;
        carry_cnt_cur = finish ? carry_cnt_fin : carry_cnt_reg;
    end

    always_comb
    begin
        word_next      = word_reg;
        j_next         = j_reg;
        rgb_buf_next   = rgb_buf_reg;
        rem_next       = rem_reg;
        pil_next       = pil_reg;
        carry_next     = carry_cur;
        carry_cnt_next = carry_cnt_cur;
        if (issue)
        begin
            j_next       = j_reg + 1'b1;
            rgb_buf_next = rgb_buf_reg >> 24;
            rem_next     = rem_reg - 3'd3;
            pil_next     = line_end ? '0 : pil_reg + 1'b1;
        end
        if (load)
        begin
            word_next      = q_entry.word;
            j_next         = '0;
            carry_next     = '0;
            carry_cnt_next = '0;
            case (carry_cnt_cur)
                2'd0:
                begin
                    rgb_buf_next = {16'b0, q_entry.word};
                    rem_next     = 3'd4;
                end
                2'd1:
                begin
                    rgb_buf_next = {8'b0, q_entry.word, carry_cur[7:0]};
                    rem_next     = 3'd5;
                end
                default:
                begin
                    rgb_buf_next = {q_entry.word, carry_cur};
                    rem_next     = 3'd6;
                end
            endcase
        end
    end

    always_comb
    begin
        lw_ext = CMPW'(cfg.line_width);
        if (lw_ext == '0)
        begin
            eff_next = CMPW'(1);
        end
        else if (lw_ext > MAXW)
        begin
            eff_next = MAXW;
        end
        else
        begin
            eff_next = lw_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            j_reg         <= '0;
            rem_reg       <= '0;
            carry_reg     <= '0;
            carry_cnt_reg <= '0;
            pil_reg       <= '0;
            eff_reg       <= CMPW'(1);
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            rem_reg       <= rem_next;
            carry_reg     <= carry_next;
            carry_cnt_reg <= carry_cnt_next;
            pil_reg       <= pil_next;
            eff_reg       <= eff_next;
            if (advance)
            begin
                s2_valid_reg  <= issue;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg    <= word_next;
        rgb_buf_reg <= rgb_buf_next;
        if (issue)
        begin
            s2_pal_reg  <= use_pal;
            s2_last_reg <= step_last;
            s2_end_reg  <= line_end;
            s2_pix_reg  <= use_direct ? {8'b0, rgb_buf_reg[23:0]} : conv_pix;
        end
        if (advance && s2_valid_reg)
        begin
            out_pix_reg  <= s2_pal_reg ? pal_q_reg : s2_pix_reg;
            out_last_reg <= s2_last_reg;
            out_end_reg  <= s2_end_reg;
        end
    end

    assign waddr = PW'(MOD_TBL[q_entry.idx]);
    assign raddr = PW'(MOD_TBL[idx]);

    always_ff @(posedge clk)
    begin
        if (pal_we)
        begin
            pal_mem[waddr] <= q_entry.word;
        end
        if (issue)
        begin
            pal_q_reg <= pal_mem[raddr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pix_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_end_reg;

    a_rem_whole_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (running && cfg.fmt == FMT_24BPP) |-> rem_reg >= 3'd3)
        else $error("24-bit byte buffer holds less than one pixel");

    a_carry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        carry_cnt_reg != 2'd3)
        else $error("24-bit carry holds three bytes");

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && line_end) |=> pil_reg == '0)
        else $error("pixel counter not cleared after line end");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s2_valid_reg) |=> out_valid_reg)
        else $error("pixel lost between lookup stage and output");

    a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && !step_last) |=> running)
        else $error("sequencer left a word before its last pixel");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bspu_pkg::*;

    localparam int MAX_LINE    = 4096;
    localparam int PAL_DEPTH   = 256;
    localparam int SETTLE      = 24;
    localparam int PHASES      = 12;
    localparam int PHASE_BEATS = 10;
    localparam int PRINT_CAP   = 40;
    localparam int PLAN_LEN    = 46;

    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
        logic        line_end;
    } pixel_beat_t;

    typedef enum logic {
        ROW_REG,
        ROW_BEAT
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_ADDR_W-1:0] addr;
        logic [31:0]           value;
        item_kind_t            cmd;
        logic [7:0]            idx;
        logic                  typed;
        pixel_beat_t           want;
    } plan_row_t;

    localparam pixel_beat_t NO_PIXEL = '0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [31:0]           cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;   // data_word, palette_index
    logic                  s_axis_tuser;   // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;   // pixel
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;   // line_end

    logic [31:0] pal_entries [PAL_DEPTH];
    int          line_pos;
    logic [15:0] carry_bytes;
    int          carry_count;
    logic [2:0]  fmt_q;
    logic [31:0] red_q;
    logic [31:0] green_q;
    logic [31:0] blue_q;
    logic [12:0] width_q;
    pixel_beat_t word_pixels [$];
    pixel_beat_t expected_pixels [$];
    int          idle_max = 9;
    int          fail_count = 0;

    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h4433_2211, KIND_DATA, 8'h00, 1'b1,
          '{32'h0033_2211, 1'b1, 1'b1}},
        '{ROW_REG, REG_LINE_WIDTH, 32'd2, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'hFFFF_FFFF, KIND_DATA, 8'hFF, 1'b1,
          '{32'h00FF_FFFF, 1'b1, 1'b0}},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h0000_0000, KIND_DATA, 8'h00, 1'b1,
          '{32'h0000_00FF, 1'b1, 1'b1}},
        '{ROW_REG, REG_LINE_WIDTH, 32'd0, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'(FMT_8BPP), KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'hFF00_0100, KIND_DATA, 8'h00, 1'b1,
          '{32'hFF00_A500, 1'b1, 1'b1}},
        '{ROW_REG, REG_LINE_WIDTH, 32'd8191, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'hFF80_0100, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'(FMT_1BPP), KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h8001_FF00, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'(FMT_4BPP), KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h0F1E_2D3C, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'(FMT_16BPP), KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_RED_MASK, 32'h0000_7C00, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_GREEN_MASK, 32'h0000_03E0, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_BLUE_MASK, 32'h0000_001F, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h7FFF_8000, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'(FMT_32BPP), KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_RED_MASK, 32'h0000_0000, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_GREEN_MASK, 32'h0000_0000, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_BLUE_MASK, 32'h0000_0000, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'hFFFF_FFFF, KIND_DATA, 8'h00, 1'b1,
          '{32'h0000_0000, 1'b1, 1'b0}},
        '{ROW_REG, REG_RED_MASK, 32'hFFFF_FFFF, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_GREEN_MASK, 32'hFFFF_FFFF, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_BLUE_MASK, 32'hFFFF_FFFF, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h8000_0001, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_LINE_WIDTH, 32'd3, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h0012_3456, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'd6, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h1234_5678, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'd7, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h8765_4321, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'hDEAD_BEEF, KIND_PAL_WR, 8'h7F, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'(FMT_8BPP), KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h7F7F_7F7F, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'(FMT_24BPP), KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_LINE_WIDTH, 32'd4096, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h3322_1100, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h7766_5544, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'hBBAA_9988, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h3322_1100, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'(FMT_32BPP), KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'h00AB_CDEF, KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_REG, REG_PIXEL_FORMAT, 32'(FMT_24BPP), KIND_DATA, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_BEAT, REG_PIXEL_FORMAT, 32'hFFEE_DDCC, KIND_DATA, 8'h00, 1'b1,
          '{32'h00EE_DDCC, 1'b1, 1'b0}}
    };

    bmp_scanline_pixel_unpacker u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] fit_channel(input logic [31:0] raw,
                                                input logic [31:0] mask,
                                                input int top,
                                                input logic [31:0] chan);
        logic [31:0] f;
        int          len;
        f   = raw & mask;
        len = 0;
        for (int b = 0; b < 32; b++)
        begin
            if (mask[b])
                len = b + 1;
        end
        if (top >= len)
            f = f << (top - len);
        else
            f = f >> (len - top);
        return f & chan;
    endfunction

    function automatic logic [31:0] to_rgb(input logic [31:0] raw);
        return fit_channel(raw, red_q, TOP_RED, CHAN_RED) |
               fit_channel(raw, green_q, TOP_GREEN, CHAN_GREEN) |
               fit_channel(raw, blue_q, TOP_BLUE, CHAN_BLUE);
    endfunction

    // Advance the line counter; true when this pixel closes the line.
    function automatic bit put_pixel(input logic [31:0] px);
        int w;
        bit ends;
        w = int'(width_q);
        if (w == 0)
            w = 1;
        if (w > MAX_LINE)
            w = MAX_LINE;
        ends = (line_pos + 1) >= w;
        word_pixels.push_back('{px, 1'b0, ends});
        if (ends)
        begin
            line_pos    = 0;
            carry_bytes = '0;
            carry_count = 0;
        end
        else
            line_pos++;
        return ends;
    endfunction

    function automatic void decode_beat(input item_kind_t cmd, input logic [7:0] idx,
                                        input logic [31:0] word);
        logic [7:0]  bytes [6];
        int          cnt;
        int          pos;
        int          cc;
        int          k;
        int          sh;
        pixel_beat_t tail;
        word_pixels.delete();
        if (cmd == KIND_PAL_WR)
        begin
            pal_entries[idx] = word;
            return;
        end
        if (fmt_q > FMT_32BPP)
            return;
        if (fmt_q != FMT_24BPP)
        begin
            carry_bytes = '0;
            carry_count = 0;
        end
        case (fmt_q)
            FMT_1BPP:
                for (int j = 0; j < 32; j++)
                begin
                    sh = (j & 24) + 7 - (j & 7);
                    if (put_pixel(pal_entries[word[sh]]))
                        break;
                end
            FMT_4BPP:
                for (int j = 0; j < 8; j++)
                begin
                    sh = 8 * (j >> 1) + (((j & 1) != 0) ? 0 : 4);
                    if (put_pixel(pal_entries[word[sh +: 4]]))
                        break;
                end
            FMT_8BPP:
                for (int j = 0; j < 4; j++)
                begin
                    if (put_pixel(pal_entries[word[8 * j +: 8]]))
                        break;
                end
            FMT_16BPP:
                for (int j = 0; j < 2; j++)
                begin
                    if (put_pixel(to_rgb({16'h0000, word[16 * j +: 16]})))
                        break;
                end
            FMT_24BPP:
            begin
                cc  = (carry_count > 2) ? 2 : carry_count;
                cnt = 0;
                pos = 0;
                for (int j = 0; j < cc; j++)
                begin
                    bytes[cnt] = carry_bytes[8 * j +: 8];
                    cnt++;
                end
                for (int j = 0; j < 4; j++)
                begin
                    bytes[cnt] = word[8 * j +: 8];
                    cnt++;
                end
                carry_bytes = '0;
                carry_count = 0;
                while (cnt - pos >= 3)
                begin
                    sh  = pos;
                    pos += 3;
                    if (put_pixel({8'h00, bytes[sh + 2], bytes[sh + 1], bytes[sh]}))
                    begin
                        pos = cnt;
                        break;
                    end
                end
                k = 0;
                while (pos < cnt)
                begin
                    carry_bytes[8 * k +: 8] = bytes[pos];
                    k++;
                    pos++;
                end
                carry_count = k;
            end
            FMT_32BPP:
                void'(put_pixel(to_rgb(word)));
            default: ;
        endcase
        if (word_pixels.size() > 0)
        begin
            tail      = word_pixels.pop_back();
            tail.last = 1'b1;
            word_pixels.push_back(tail);
        end
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (addr)
            REG_PIXEL_FORMAT: fmt_q   = value[2:0];
            REG_RED_MASK:     red_q   = value;
            REG_GREEN_MASK:   green_q = value;
            REG_BLUE_MASK:    blue_q  = value;
            REG_LINE_WIDTH:   width_q = value[12:0];
            default: ;
        endcase
    endtask

    task automatic send_beat(input item_kind_t cmd, input logic [7:0] idx,
                             input logic [31:0] word, input logic typed,
                             input pixel_beat_t want);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {word, idx};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        decode_beat(cmd, idx, word);
        if (typed)
            expected_pixels.push_back(want);
        else
        begin
            foreach (word_pixels[i])
                expected_pixels.push_back(word_pixels[i]);
        end
    endtask

    // Hold the input idle until every pending pixel is out and the pipe is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_masks();
        case ($urandom_range(0, 4))
            0:
            begin
                write_reg(REG_RED_MASK, CHAN_RED);
                write_reg(REG_GREEN_MASK, CHAN_GREEN);
                write_reg(REG_BLUE_MASK, CHAN_BLUE);
            end
            1:
            begin
                write_reg(REG_RED_MASK, 32'h0000_7C00);
                write_reg(REG_GREEN_MASK, 32'h0000_03E0);
                write_reg(REG_BLUE_MASK, 32'h0000_001F);
            end
            2:
            begin
                write_reg(REG_RED_MASK, 32'h0000_F800);
                write_reg(REG_GREEN_MASK, 32'h0000_07E0);
                write_reg(REG_BLUE_MASK, 32'h0000_001F);
            end
            3:
            begin
                write_reg(REG_RED_MASK, $urandom());
                write_reg(REG_GREEN_MASK, $urandom());
                write_reg(REG_BLUE_MASK, $urandom());
            end
            default:
            begin
                write_reg(REG_RED_MASK, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
                write_reg(REG_GREEN_MASK, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
                write_reg(REG_BLUE_MASK, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
            end
        endcase
    endtask

    function automatic logic [31:0] draw_width();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd4096;
            2:       return 32'd8191;
            3:       return $urandom_range(1, 8191);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    initial
    begin
        int pick;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_DATA;
        line_pos    = 0;
        carry_bytes = '0;
        carry_count = 0;
        fmt_q       = FMT_24BPP;
        red_q       = CHAN_RED;
        green_q     = CHAN_GREEN;
        blue_q      = CHAN_BLUE;
        width_q     = 13'd1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole palette before any lookup can touch it.
        for (int i = 0; i < PAL_DEPTH; i++)
            send_beat(KIND_PAL_WR, 8'(i), {~8'(i), 8'(i), 8'(i) ^ 8'hA5, 8'(i)}, 1'b0,
                      NO_PIXEL);

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_REG)
            begin
                settle();
                write_reg(plan[r].addr, plan[r].value);
            end
            else
                send_beat(plan[r].cmd, plan[r].idx, plan[r].value, plan[r].typed,
                          plan[r].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            idle_max = ($urandom_range(0, 3) == 0) ? 0 : 9;
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_PIXEL_FORMAT, $urandom_range(6, 7));
            else
                write_reg(REG_PIXEL_FORMAT, $urandom_range(0, 5));
            if ($urandom_range(0, 1))
                write_masks();
            if ($urandom_range(0, 1))
                write_reg(REG_LINE_WIDTH, draw_width());
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    send_beat(KIND_PAL_WR, 8'($urandom()), $urandom(), 1'b0, NO_PIXEL);
                else if (pick < 14)
                    send_beat(KIND_DATA, 8'($urandom()), 32'h0000_0000, 1'b0, NO_PIXEL);
                else if (pick < 18)
                    send_beat(KIND_DATA, 8'($urandom()), 32'hFFFF_FFFF, 1'b0, NO_PIXEL);
                else
                    send_beat(KIND_DATA, 8'($urandom()), $urandom(), 1'b0, NO_PIXEL);
            end
        end

        settle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int stall;
        forever
        begin
            stall = $urandom_range(0, idle_max);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (m_axis_tvalid !== 1'b1 || rst_n !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        pixel_beat_t want;
        if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (expected_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= PRINT_CAP)
                    $display("%0t: unexpected pixel beat %h last %b line_end %b", $time,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata !== want.pixel || m_axis_tlast !== want.last ||
                    m_axis_tuser !== want.line_end)
                begin
                    fail_count++;
                    if (fail_count <= PRINT_CAP)
                        $display("%0t: expected pixel %h last %b line_end %b, got %h %b %b",
                                 $time, want.pixel, want.last, want.line_end,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
design/bspu_pkg.sv
design/bspu_front.sv
design/bspu_fifo.sv
design/bspu_back.sv
design/bmp_scanline_pixel_unpacker.sv
tb/sv/tb.sv
